// ----- sv/compass_heading_from_xy_unit_macros.svh -----
// Assertion macros shared by the compass heading block.
`ifndef COMPASS_HEADING_FROM_XY_UNIT_MACROS_SVH
`define COMPASS_HEADING_FROM_XY_UNIT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define CHXY_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition implies a second condition in the same cycle.
`define CHXY_ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

// ----- sv/chxy_pkg.sv -----
package chxy_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int IDXW = 5;
    localparam int XW = 36;
    localparam int ZW = 26;
    localparam int HW = 9;
    localparam int LATENCY = CORDIC_STEPS + 2;

    localparam logic signed [ZW-1:0] Z_PLUS_90 = ZW'(90 * 65536);
    localparam logic signed [ZW-1:0] Z_MINUS_90 = -ZW'(90 * 65536);
    localparam logic signed [ZW:0] Z_OFFSET_180 = (ZW + 1)'(180 * 65536);
    localparam logic signed [ZW:0] Q16_ROUND_UP = (ZW + 1)'(65535);

    localparam logic [HW-1:0] HEAD_45 = HW'(45);
    localparam logic [HW-1:0] HEAD_90 = HW'(90);
    localparam logic [HW-1:0] HEAD_135 = HW'(135);
    localparam logic [HW-1:0] HEAD_180 = HW'(180);
    localparam logic [HW-1:0] HEAD_225 = HW'(225);
    localparam logic [HW-1:0] HEAD_270 = HW'(270);
    localparam logic [HW-1:0] HEAD_315 = HW'(315);
    localparam logic [HW-1:0] HEAD_360 = HW'(360);
    localparam logic [HW-1:0] HEAD_MIN = HW'(1);

    typedef struct packed {
        logic                 special;
        logic [HW-1:0]        spec_heading;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } chxy_stage_t;

    function automatic logic signed [ZW-1:0] atan_q16(input logic [IDXW-1:0] idx);
        logic signed [ZW-1:0] val;
        case (idx)
            5'd0: val = ZW'(2949120);
            5'd1: val = ZW'(1740967);
            5'd2: val = ZW'(919879);
            5'd3: val = ZW'(466945);
            5'd4: val = ZW'(234379);
            5'd5: val = ZW'(117304);
            5'd6: val = ZW'(58666);
            5'd7: val = ZW'(29335);
            5'd8: val = ZW'(14668);
            5'd9: val = ZW'(7334);
            5'd10: val = ZW'(3667);
            5'd11: val = ZW'(1833);
            5'd12: val = ZW'(917);
            5'd13: val = ZW'(458);
            5'd14: val = ZW'(229);
            5'd15: val = ZW'(115);
            5'd16: val = ZW'(57);
            5'd17: val = ZW'(29);
            5'd18: val = ZW'(14);
            5'd19: val = ZW'(7);
            5'd20: val = ZW'(4);
            5'd21: val = ZW'(2);
            5'd22: val = ZW'(1);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ----- sv/chxy_prep.sv -----
module chxy_prep
    import chxy_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic signed [15:0]  raw_x,
    input  logic signed [15:0]  raw_y,
    output logic                out_valid,
    output chxy_stage_t         out_data
);

    logic signed [15:0]   nx;
    logic signed [15:0]   ny;
    logic [16:0]          ax;
    logic [16:0]          ay;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    chxy_stage_t          data_next;
    chxy_stage_t          data_reg;
    logic                 valid_reg;

    always_comb
    begin
        nx = 16'(16'sd0 - raw_x);
        ny = 16'(16'sd0 - raw_y);
        ax = nx[15] ? (17'd0 - {nx[15], nx}) : {1'b0, nx};
        ay = ny[15] ? (17'd0 - {ny[15], ny}) : {1'b0, ny};
        xs = {{(XW - 32){nx[15]}}, nx, 16'd0};
        ys = {{(XW - 32){ny[15]}}, ny, 16'd0};

        data_next.special = 1'b1;
        data_next.spec_heading = HEAD_180;
        if (ny == 16'sd0)
        begin
            data_next.spec_heading = nx[15] ? HEAD_360 : HEAD_180;
        end
        else if (nx == 16'sd0)
        begin
            data_next.spec_heading = ny[15] ? HEAD_90 : HEAD_270;
        end
        else if (ax == ay)
        begin
            if (!nx[15])
            begin
                data_next.spec_heading = ny[15] ? HEAD_135 : HEAD_225;
            end
            else
            begin
                data_next.spec_heading = ny[15] ? HEAD_45 : HEAD_315;
            end
        end
        else
        begin
            data_next.special = 1'b0;
        end

        data_next.x = xs;
        data_next.y = ys;
        data_next.z = '0;
        if (nx[15])
        begin
            if (!ny[15])
            begin
                data_next.x = ys;
                data_next.y = XW'(-xs);
                data_next.z = Z_PLUS_90;
            end
            else
            begin
                data_next.x = XW'(-ys);
                data_next.y = xs;
                data_next.z = Z_MINUS_90;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

endmodule

// ----- sv/chxy_cell.sv -----
module chxy_cell
    import chxy_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [IDXW-1:0] stage_idx,
    input  logic            in_valid,
    input  chxy_stage_t     in_data,
    output logic            out_valid,
    output chxy_stage_t     out_data
);

    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [ZW-1:0] da;
    chxy_stage_t          data_next;
    chxy_stage_t          data_reg;
    logic                 valid_reg;

    always_comb
    begin
        dx = in_data.x;
        dy = in_data.y;
        dx = $signed(in_data.y) >>> stage_idx;
        dy = $signed(in_data.x) >>> stage_idx;
        da = atan_q16(stage_idx);
        data_next = in_data;
        if ($signed(in_data.y) > $signed(XW'(0)))
        begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + da;
        end
        else
        begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - da;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

endmodule

// ----- sv/chxy_post.sv -----
module chxy_post
    import chxy_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  chxy_stage_t   in_data,
    output logic          done,
    output logic [HW-1:0] heading_deg
);

    logic signed [ZW:0] u;
    logic signed [ZW:0] u_up;
    logic [ZW-17:0]     h;
    logic [HW-1:0]      heading_next;
    logic [HW-1:0]      heading_reg;
    logic               done_reg;

    always_comb
    begin
        u = $signed({in_data.z[ZW-1], in_data.z}) + Z_OFFSET_180;
        u_up = u + Q16_ROUND_UP;
        h = u_up[ZW-1:16];
        if (in_data.special)
        begin
            heading_next = in_data.spec_heading;
        end
        else if (u <= $signed((ZW + 1)'(0)))
        begin
            heading_next = HEAD_MIN;
        end
        else if (h > (ZW - 16)'(HEAD_360))
        begin
            heading_next = HEAD_360;
        end
        else if (h < (ZW - 16)'(HEAD_MIN))
        begin
            heading_next = HEAD_MIN;
        end
        else
        begin
            heading_next = h[HW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        heading_reg <= heading_next;
    end

    assign done = done_reg;
    assign heading_deg = heading_reg;

endmodule

// ----- sv/compass_heading_from_xy_unit.sv -----
// Turns one raw X/Y magnetometer sample into a whole-degree heading from 1 to 360.
// A transaction is taken on every clock with start high; busy never rises, so samples
// may stream back to back at one per cycle. Each heading appears on heading_deg for
// exactly one cycle with done high, after passing through one register for the input
// negation and pre-rotation, one per CORDIC cell and one for rounding. The receiver
// cannot stall the output: it must take each heading in the cycle that done marks.
`include "compass_heading_from_xy_unit_macros.svh"

module compass_heading_from_xy_unit
    import chxy_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] raw_x,
    input  logic signed [15:0] raw_y,
    output logic               done,
    output logic [HW-1:0]      heading_deg
);

    logic        stage_valid [0:CORDIC_STEPS];
    chxy_stage_t stage_data [0:CORDIC_STEPS];

    assign busy = 1'b0;

    chxy_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .raw_x     (raw_x),
        .raw_y     (raw_y),
        .out_valid (stage_valid[0]),
        .out_data  (stage_data[0])
    );

    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_cell
        chxy_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_idx (IDXW'(g)),
            .in_valid  (stage_valid[g]),
            .in_data   (stage_data[g]),
            .out_valid (stage_valid[g + 1]),
            .out_data  (stage_data[g + 1])
        );
    end

    chxy_post u_post
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (stage_valid[CORDIC_STEPS]),
        .in_data     (stage_data[CORDIC_STEPS]),
        .done        (done),
        .heading_deg (heading_deg)
    );

    `CHXY_ASSERT_IMPL(a_heading_range, done,
        (heading_deg >= HEAD_MIN) && (heading_deg <= HEAD_360), "heading out of range")
    `CHXY_ASSERT(a_start_to_done, start |-> ##LATENCY done, "transaction lost in pipeline")
    `CHXY_ASSERT(a_no_spurious_done, !start |-> ##LATENCY !done, "result without transaction")

endmodule

// ----- verif/tb_compass_heading_from_xy_unit.sv -----
module tb_compass_heading_from_xy_unit;
    import chxy_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_SAMPLES = 1600;
    localparam int QUIET_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;
    localparam int ATAN_LEN = 25;
    localparam longint Q16 = 65536;
    localparam longint ATAN_DEG_Q16 [0:ATAN_LEN-1] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0, 0
    };

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        int unsigned        gap;
    } sample_t;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [HW-1:0]      heading;
    } heading_entry_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic signed [15:0] raw_x = '0;
    logic signed [15:0] raw_y = '0;
    logic               busy;
    logic               done;
    logic [HW-1:0]      heading_deg;

    sample_t        pending_samples[$];
    heading_entry_t expected_headings[$];
    sample_t        next_sample;
    heading_entry_t oldest_heading;
    int unsigned    idle_left;
    logic           gap_served;
    int unsigned    mismatches = 0;
    int unsigned    quiet_cycles = 0;

    compass_heading_from_xy_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .raw_x       (raw_x),
        .raw_y       (raw_y),
        .done        (done),
        .heading_deg (heading_deg)
    );

    always #1 clk = ~clk;

    function automatic logic [HW-1:0] heading_of_sample(input logic signed [15:0] sx,
                                                       input logic signed [15:0] sy);
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        longint x;
        longint y;
        longint z;
        longint swap;
        longint dx;
        longint dy;
        longint u;
        longint h;
        int ax;
        int ay;
        int steps;
        nx = -sx;
        ny = -sy;
        if (ny == 0)
            return (nx < 0) ? HW'(360) : HW'(180);
        if (nx == 0)
            return (ny > 0) ? HW'(270) : HW'(90);
        ax = (nx < 0) ? -int'(nx) : int'(nx);
        ay = (ny < 0) ? -int'(ny) : int'(ny);
        if (ax == ay)
        begin
            if (nx > 0)
                return (ny > 0) ? HW'(225) : HW'(135);
            return (ny > 0) ? HW'(315) : HW'(45);
        end
        x = longint'(nx) * Q16;
        y = longint'(ny) * Q16;
        z = 0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                swap = y;
                y = -x;
                x = swap;
                z = 90 * Q16;
            end
            else
            begin
                swap = -y;
                y = x;
                x = swap;
                z = -90 * Q16;
            end
        end
        steps = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
        for (int i = 0; i < steps; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_DEG_Q16[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_DEG_Q16[i];
            end
        end
        u = z + 180 * Q16;
        if (u <= 0)
            return HW'(1);
        h = (u + Q16 - 1) / Q16;
        if (h < 1)
            h = 1;
        if (h > 360)
            h = 360;
        return HW'(h);
    endfunction

    function automatic int unsigned draw_gap(input logic no_idle);
        return no_idle ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic logic signed [15:0] signed_mag(input int unsigned mag);
        logic signed [15:0] v;
        v = 16'(mag);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            raw_x <= '0;
            raw_y <= '0;
            idle_left <= 0;
            gap_served <= 1'b0;
        end
        else
        begin
            if (start && !busy)
                expected_headings.push_back('{x: raw_x, y: raw_y,
                                              heading: heading_of_sample(raw_x, raw_y)});
            if (!(start && busy))
            begin
                if (idle_left != 0)
                begin
                    start <= 1'b0;
                    idle_left <= idle_left - 1;
                end
                else if (pending_samples.size() != 0)
                begin
                    if (pending_samples[0].gap != 0 && !gap_served)
                    begin
                        start <= 1'b0;
                        idle_left <= pending_samples[0].gap - 1;
                        gap_served <= 1'b1;
                    end
                    else
                    begin
                        next_sample = pending_samples.pop_front();
                        start <= 1'b1;
                        raw_x <= next_sample.x;
                        raw_y <= next_sample.y;
                        gap_served <= 1'b0;
                    end
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (expected_headings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected heading %0d with no transaction pending",
                             heading_deg);
            end
            else
            begin
                oldest_heading = expected_headings.pop_front();
                if (heading_deg !== oldest_heading.heading)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("heading mismatch for x=%0d y=%0d: expected %0d, got %0d",
                                 oldest_heading.x, oldest_heading.y,
                                 oldest_heading.heading, heading_deg);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done === 1'b1)
                quiet_cycles <= 0;
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("timeout with %0d headings outstanding",
                             expected_headings.size());
                    $display("CHECKS FAILED");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        logic signed [15:0] corner [0:21][0:1];
        logic no_idle;
        int unsigned mag;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        corner = '{
            '{16'sd0, 16'sd0}, '{16'sd1, 16'sd0}, '{-16'sd1, 16'sd0},
            '{16'sd0, 16'sd1}, '{16'sd0, -16'sd1},
            '{-16'sd32768, 16'sd0}, '{16'sd32767, 16'sd0},
            '{16'sd0, -16'sd32768}, '{16'sd0, 16'sd32767},
            '{-16'sd32768, -16'sd32768}, '{16'sd32767, 16'sd32767},
            '{16'sd32767, -16'sd32767}, '{-16'sd32767, 16'sd32767},
            '{16'sd100, 16'sd100}, '{16'sd100, -16'sd100},
            '{-16'sd100, 16'sd100}, '{-16'sd100, -16'sd100},
            '{-16'sd32768, 16'sd1}, '{-16'sd32768, -16'sd1},
            '{16'sd32767, -16'sd32768}, '{-16'sd32768, 16'sd32767},
            '{16'sd3, -16'sd7}
        };
        for (int i = 0; i < 22; i++)
            pending_samples.push_back('{x: corner[i][0], y: corner[i][1],
                                        gap: $urandom_range(0, 3)});
        no_idle = 1'b0;
        for (int i = 0; i < RANDOM_SAMPLES; i++)
        begin
            if (i % 64 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    sx = 16'($urandom_range(0, 16)) - 16'sd8;
                    sy = 16'($urandom_range(0, 16)) - 16'sd8;
                end
                2:
                begin
                    mag = $urandom_range(1, 32767);
                    sx = signed_mag(mag);
                    sy = signed_mag(mag);
                end
                3:
                begin
                    sx = 16'($urandom);
                    sy = 16'($urandom_range(0, 6)) - 16'sd3;
                    if ($urandom_range(0, 1))
                    begin
                        sy = sx;
                        sx = 16'($urandom_range(0, 6)) - 16'sd3;
                    end
                end
                default:
                begin
                    sx = 16'($urandom);
                    sy = 16'($urandom);
                end
            endcase
            pending_samples.push_back('{x: sx, y: sy, gap: draw_gap(no_idle)});
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_samples.size() != 0 || start)
            @(posedge clk);
        while (expected_headings.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        if (mismatches == 0 && expected_headings.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
